@@ hdl/vna_pkg.sv @@
// Package for the vertex normal accumulator: shared constants, codes and the
// controller/datapath command and status structs. No dependencies.
package vna_pkg;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_POS_BITS     = 16;
    localparam int DEF_ACC_BITS     = 48;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LATCH     = 4'd1;
    localparam logic [3:0] OP_POS_WRITE = 4'd2;
    localparam logic [3:0] OP_POS_RD    = 4'd3;
    localparam logic [3:0] OP_EDGE      = 4'd4;
    localparam logic [3:0] OP_CROSS     = 4'd5;
    localparam logic [3:0] OP_ACC_RD    = 4'd6;
    localparam logic [3:0] OP_ACC_WR    = 4'd7;
    localparam logic [3:0] OP_CLR       = 4'd8;
    localparam logic [3:0] OP_NORM      = 4'd9;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] sel;
    } vna_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       idx_ok;
        logic       tri_ok;
        logic       clr_done;
        logic       norm_done;
    } vna_status_t;

endpackage

@@ hdl/vertex_normal_accumulator_core.sv @@
// Top level of the area-weighted vertex normal accumulator.
// Depends on vna_pkg, vna_ctrl, vna_datapath.

// One item is taken at a time. A triangle add runs three position reads, two cross
// product steps, then three accumulator read-modify-writes on the single accumulator
// port; a clear writes one accumulator entry per cycle; a normal read runs the
// magnitude scaling, the bit-serial square root (31 steps) and three 17-step
// divisions, then waits on m_tready, while a zero normal skips the root and the
// divisions. After reset the accumulators are swept to zero the same way, so
// s_tready stays low until that sweep is done.
// Out-of-range indices are ignored, and a read of one returns zeros with the
// degenerate flag set.
module vertex_normal_accumulator_core #(
    parameter int MAX_VERTICES = vna_pkg::DEF_MAX_VERTICES,
    parameter int POS_BITS     = vna_pkg::DEF_POS_BITS,
    parameter int ACC_BITS     = vna_pkg::DEF_ACC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[1:0], vertex_index[11:2], pos_x[27:12], pos_y[43:28], pos_z[59:44],
    // corner_a[69:60], corner_b[79:70], corner_c[89:80], zero fill[95:90]
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // normal_vertex[9:0], normal_x[25:10], normal_y[41:26], normal_z[57:42],
    // zero fill[63:58]
    output logic [63:0] m_tdata,
    // degenerate[0]
    output logic        m_tuser
);
    import vna_pkg::*;

    vna_cmd_t    cmd;
    vna_status_t status;
    logic        bad;
    logic [9:0]  nv;
    logic [15:0] nx, ny, nz;
    logic        dg;

    vna_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(s_tvalid && s_tready), .in_ready(s_tready),
        .out_ready(m_tready), .out_valid(m_tvalid), .out_bad(bad),
        .cmd(cmd), .status(status)
    );

    vna_datapath #(
        .MAX_VERTICES(MAX_VERTICES), .POS_BITS(POS_BITS), .ACC_BITS(ACC_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .in_action(s_tdata[1:0]), .in_vi(s_tdata[11:2]), .in_x(s_tdata[27:12]),
        .in_y(s_tdata[43:28]), .in_z(s_tdata[59:44]), .in_a(s_tdata[69:60]),
        .in_b(s_tdata[79:70]), .in_c(s_tdata[89:80]),
        .out_vi(nv), .out_x(nx), .out_y(ny), .out_z(nz), .out_degen(dg)
    );

    assign m_tdata = {6'b0, bad ? 16'd0 : nz, bad ? 16'd0 : ny, bad ? 16'd0 : nx, nv};
    assign m_tuser = bad | dg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result is pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped before it was taken");
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[57:10] == 48'd0)
        else $error("degenerate normal with nonzero components");
`endif
endmodule

@@ hdl/vna_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module vna_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ hdl/vna_norm.sv @@
// Iterative normalizer: magnitude scaling, square root and three divisions.
// Depends on vna_pkg.
module vna_norm #(
    parameter int ACC_BITS = 48
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [ACC_BITS-1:0] ax,
    input  logic signed [ACC_BITS-1:0] ay,
    input  logic signed [ACC_BITS-1:0] az,
    output logic                       done,
    output logic [15:0]                nx,
    output logic [15:0]                ny,
    output logic [15:0]                nz,
    output logic                       degen
);
    import vna_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_SQ    = 3'd2;
    localparam logic [2:0] S_SQRT  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [ACC_BITS-1:0] m_reg [3];
    logic [2:0]          sgn_reg;
    logic [1:0]          k_reg;
    logic [61:0]         sum_reg;
    logic [61:0]         rem_reg;
    logic [31:0]         res_reg;
    logic [4:0]          cnt_reg;
    logic [45:0]         dnum_reg;
    logic [16:0]         q_reg;
    logic [15:0]         out_reg [3];
    logic                degen_reg;

    logic [ACC_BITS-1:0] mg [3];
    logic [ACC_BITS-1:0] big;
    logic [ACC_BITS-1:0] mk;
    logic [61:0]         trial;
    logic [61:0]         rem_cur;
    logic                sq_ge;
    logic [45:0]         dv_num;
    logic [46:0]         dv_r;
    logic                dv_ge;
    logic [16:0]         q_fin;

    always_comb
    begin
        mg[0] = ax[ACC_BITS-1] ? ACC_BITS'(-ax) : ACC_BITS'(ax);
        mg[1] = ay[ACC_BITS-1] ? ACC_BITS'(-ay) : ACC_BITS'(ay);
        mg[2] = az[ACC_BITS-1] ? ACC_BITS'(-az) : ACC_BITS'(az);
        big = m_reg[0];
        if (m_reg[1] > big) big = m_reg[1];
        if (m_reg[2] > big) big = m_reg[2];
        mk      = m_reg[k_reg];
        trial   = ({30'b0, res_reg} << ({1'b0, cnt_reg} + 6'd1)) | (62'd1 << {cnt_reg, 1'b0});
        rem_cur = (cnt_reg == 5'd30) ? sum_reg : rem_reg;
        sq_ge   = (rem_cur >= trial);
        // Restoring division of (m<<14)+len/2 by len, one quotient bit per cycle.
        dv_num  = {2'b0, mk[29:0], 14'b0} + 46'(res_reg >> 1);
        if (cnt_reg == 5'd16) dv_r = 47'(dv_num >> 16);
        else dv_r = {dnum_reg, dv_num[6'(cnt_reg)]};
        dv_ge   = (dv_r >= 47'(res_reg));
        q_fin   = {q_reg[15:0], dv_ge};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_SHIFT;
            S_SHIFT:
            begin
                if (big == '0) state_next = S_DONE;
                else if (big < (ACC_BITS'(1) << 29) || big >= (ACC_BITS'(1) << 30))
                    state_next = S_SHIFT;
                else state_next = S_SQ;
            end
            S_SQ:    if (k_reg == 2'd2) state_next = S_SQRT;
            S_SQRT:  if (cnt_reg == 5'd0) state_next = S_DIV;
            S_DIV:   if (cnt_reg == 5'd0 && k_reg == 2'd2) state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Square root keeps res as the root so far; trial is 2*res*2^i+2^(2i),
    // written as (res << (i+1)) | (1 << 2i), with res held at its final bit positions.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++) m_reg[i] <= mg[i];
                    sgn_reg   <= {az[ACC_BITS-1], ay[ACC_BITS-1], ax[ACC_BITS-1]};
                    degen_reg <= 1'b0;
                    k_reg     <= 2'd0;
                    sum_reg   <= '0;
                end
            end
            S_SHIFT:
            begin
                if (big == '0)
                begin
                    degen_reg <= 1'b1;
                    for (int i = 0; i < 3; i++) out_reg[i] <= '0;
                end
                else if (big >= (ACC_BITS'(1) << 30))
                    for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] >> 1;
                else if (big < (ACC_BITS'(1) << 29))
                    for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] << 1;
            end
            S_SQ:
            begin
                sum_reg <= sum_reg + 62'(mk[29:0] * mk[29:0]);
                k_reg   <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                cnt_reg <= 5'd30;
                res_reg <= '0;
            end
            S_SQRT:
            begin
                rem_reg <= sq_ge ? rem_cur - trial : rem_cur;
                if (sq_ge)
                begin
                    res_reg <= res_reg | (32'd1 << cnt_reg);
                end
                if (cnt_reg == 5'd0)
                begin
                    cnt_reg  <= 5'd16;
                    dnum_reg <= '0;
                    q_reg    <= '0;
                end
                else cnt_reg <= cnt_reg - 5'd1;
            end
            S_DIV:
            begin
                if (cnt_reg == 5'd0)
                begin
                    out_reg[k_reg] <= sgn_reg[k_reg] ? 16'(-q_fin) : 16'(q_fin);
                    cnt_reg  <= 5'd16;
                    dnum_reg <= '0;
                    q_reg    <= '0;
                    k_reg    <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                end
                else
                begin
                    dnum_reg <= dv_ge ? 46'(dv_r - 47'(res_reg)) : 46'(dv_r);
                    q_reg    <= q_fin;
                    cnt_reg  <= cnt_reg - 5'd1;
                end
            end
            default: ;
        endcase
    end

    assign done  = (state_reg == S_DONE);
    assign nx    = out_reg[0];
    assign ny    = out_reg[1];
    assign nz    = out_reg[2];
    assign degen = degen_reg;
endmodule

@@ hdl/vna_datapath.sv @@
// Datapath: position and accumulator memories, edge/cross arithmetic,
// saturating adds, clear sweep and normalizer. Depends on vna_pkg, vna_ram, vna_norm.
module vna_datapath #(
    parameter int MAX_VERTICES = 1024,
    parameter int POS_BITS     = 16,
    parameter int ACC_BITS     = 48
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  vna_pkg::vna_cmd_t        cmd,
    output vna_pkg::vna_status_t     status,
    input  logic [1:0]               in_action,
    input  logic [9:0]               in_vi,
    input  logic [15:0]              in_x,
    input  logic [15:0]              in_y,
    input  logic [15:0]              in_z,
    input  logic [9:0]               in_a,
    input  logic [9:0]               in_b,
    input  logic [9:0]               in_c,
    output logic [9:0]               out_vi,
    output logic [15:0]              out_x,
    output logic [15:0]              out_y,
    output logic [15:0]              out_z,
    output logic                     out_degen
);
    import vna_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int EB = POS_BITS + 1;
    localparam int PB = 2 * EB;
    localparam int CB = PB + 1;

    logic [1:0]  act_reg;
    logic [9:0]  vi_reg, a_reg, b_reg, c_reg;
    logic [15:0] px_reg, py_reg, pz_reg;
    logic [AW:0] clr_reg;
    logic        clr_done_reg;
    logic        norm_done;

    logic signed [POS_BITS-1:0] pa_reg [3];
    logic signed [EB-1:0]       e1_reg [3], e2_reg [3];
    logic signed [PB-1:0]       pr_reg [6];
    logic signed [ACC_BITS-1:0] n_reg [3];

    logic [AW-1:0]            pos_addr, acc_addr;
    logic                     pos_we, acc_we;
    logic [3*POS_BITS-1:0]    pos_wdata, pos_rdata;
    logic signed [ACC_BITS-1:0] acc_wd [3], acc_rd [3];

    logic [9:0] sel_idx;
    always_comb
    begin
        unique case (cmd.sel)
            2'd0:    sel_idx = a_reg;
            2'd1:    sel_idx = b_reg;
            2'd2:    sel_idx = c_reg;
            default: sel_idx = vi_reg;
        endcase
    end

    assign pos_we    = (cmd.op == OP_POS_WRITE);
    assign pos_addr  = AW'(sel_idx);
    assign pos_wdata = {POS_BITS'($signed(pz_reg)), POS_BITS'($signed(py_reg)),
                        POS_BITS'($signed(px_reg))};
    assign acc_we    = (cmd.op == OP_ACC_WR) || (cmd.op == OP_CLR);
    assign acc_addr  = (cmd.op == OP_CLR) ? clr_reg[AW-1:0] : AW'(sel_idx);

    vna_ram #(.WIDTH(3 * POS_BITS), .DEPTH(MAX_VERTICES)) u_pos (
        .clk(clk), .we(pos_we), .addr(pos_addr), .wdata(pos_wdata), .rdata(pos_rdata)
    );

    localparam logic signed [ACC_BITS-1:0] AMAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] AMIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    for (genvar g = 0; g < 3; g++)
    begin : g_acc
        logic signed [ACC_BITS:0] s;
        assign s = {acc_rd[g][ACC_BITS-1], acc_rd[g]} + {n_reg[g][ACC_BITS-1], n_reg[g]};
        always_comb
        begin
            if (cmd.op == OP_CLR) acc_wd[g] = '0;
            else if (s > $signed({AMAX[ACC_BITS-1], AMAX})) acc_wd[g] = AMAX;
            else if (s < $signed({AMIN[ACC_BITS-1], AMIN})) acc_wd[g] = AMIN;
            else acc_wd[g] = s[ACC_BITS-1:0];
        end
        vna_ram #(.WIDTH(ACC_BITS), .DEPTH(MAX_VERTICES)) u_acc (
            .clk(clk), .we(acc_we), .addr(acc_addr), .wdata(acc_wd[g]), .rdata(acc_rd[g])
        );
    end

    logic signed [POS_BITS-1:0] pr [3];
    assign pr[0] = pos_rdata[POS_BITS-1:0];
    assign pr[1] = pos_rdata[2*POS_BITS-1:POS_BITS];
    assign pr[2] = pos_rdata[3*POS_BITS-1:2*POS_BITS];

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LATCH)
        begin
            act_reg <= in_action; vi_reg <= in_vi;
            px_reg <= in_x; py_reg <= in_y; pz_reg <= in_z;
            a_reg <= in_a; b_reg <= in_b; c_reg <= in_c;
        end
        // Position data arrives in the cycle after its OP_POS_RD and is taken with the next sel.
        if (cmd.op == OP_POS_RD || cmd.op == OP_EDGE)
        begin
            unique case (cmd.sel)
                2'd1:    for (int i = 0; i < 3; i++) pa_reg[i] <= pr[i];
                2'd2:    for (int i = 0; i < 3; i++) e1_reg[i] <= EB'(pr[i]) - EB'(pa_reg[i]);
                2'd3:    for (int i = 0; i < 3; i++) e2_reg[i] <= EB'(pr[i]) - EB'(pa_reg[i]);
                default: ;
            endcase
        end
        if (cmd.op == OP_CROSS && cmd.sel == 2'd0)
        begin
            pr_reg[0] <= e1_reg[1] * e2_reg[2];
            pr_reg[1] <= e1_reg[2] * e2_reg[1];
            pr_reg[2] <= e1_reg[2] * e2_reg[0];
            pr_reg[3] <= e1_reg[0] * e2_reg[2];
            pr_reg[4] <= e1_reg[0] * e2_reg[1];
            pr_reg[5] <= e1_reg[1] * e2_reg[0];
        end
        if (cmd.op == OP_CROSS && cmd.sel == 2'd1)
        begin
            for (int i = 0; i < 3; i++)
                n_reg[i] <= ACC_BITS'(CB'(pr_reg[2*i]) - CB'(pr_reg[2*i+1]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (cmd.op == OP_CLR)
        begin
            clr_reg      <= clr_reg + 1'b1;
            clr_done_reg <= (clr_reg == (AW+1)'(MAX_VERTICES - 1));
        end
        else
        begin
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
        end
    end

    vna_norm #(.ACC_BITS(ACC_BITS)) u_norm (
        .clk(clk), .rst_n(rst_n), .start(cmd.op == OP_NORM),
        .ax(acc_rd[0]), .ay(acc_rd[1]), .az(acc_rd[2]),
        .done(norm_done), .nx(out_x), .ny(out_y), .nz(out_z), .degen(out_degen)
    );

    assign status.action    = act_reg;
    assign status.idx_ok    = (32'(vi_reg) < MAX_VERTICES);
    assign status.tri_ok    = (32'(a_reg) < MAX_VERTICES) && (32'(b_reg) < MAX_VERTICES)
                              && (32'(c_reg) < MAX_VERTICES);
    assign status.clr_done  = clr_done_reg;
    assign status.norm_done = norm_done;
    assign out_vi           = vi_reg;
endmodule

@@ hdl/vna_ctrl.sv @@
// Controller state machine sequencing the datapath for each action.
// Depends on vna_pkg.
module vna_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    output logic                 in_ready,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 out_bad,
    output vna_pkg::vna_cmd_t    cmd,
    input  vna_pkg::vna_status_t status
);
    import vna_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_PRD   = 4'd2;
    localparam logic [3:0] S_CROSS = 4'd3;
    localparam logic [3:0] S_ARD   = 4'd4;
    localparam logic [3:0] S_AWAIT = 4'd5;
    localparam logic [3:0] S_AWR   = 4'd6;
    localparam logic [3:0] S_CLR   = 4'd7;
    localparam logic [3:0] S_RRD   = 4'd8;
    localparam logic [3:0] S_RWAIT = 4'd9;
    localparam logic [3:0] S_NORM  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       bad_reg, bad_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        bad_next   = bad_reg;
        cmd        = '{op: OP_NONE, sel: 2'd3};
        unique case (state_reg)
            S_IDLE:
            if (in_fire)
            begin
                cmd.op     = OP_LATCH;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                step_next = 3'd0;
                unique case (status.action)
                    ACT_WRITE:
                    begin
                        if (status.idx_ok) cmd.op = OP_POS_WRITE;
                        state_next = S_IDLE;
                    end
                    ACT_ADD:   state_next = status.tri_ok ? S_PRD : S_IDLE;
                    ACT_READ:
                    begin
                        bad_next   = !status.idx_ok;
                        state_next = status.idx_ok ? S_RRD : S_OUT;
                    end
                    default:   state_next = S_CLR;
                endcase
            end
            S_PRD:
            begin
                // Read a, b, c; each result is taken in the step whose sel is one higher.
                cmd.op    = OP_POS_RD;
                cmd.sel   = step_reg[1:0];
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3)
                begin
                    step_next  = 3'd0;
                    state_next = S_CROSS;
                end
            end
            S_CROSS:
            begin
                cmd.op    = OP_CROSS;
                cmd.sel   = step_reg[1:0];
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd1)
                begin
                    step_next  = 3'd0;
                    state_next = S_ARD;
                end
            end
            S_ARD:
            begin
                cmd.op     = OP_ACC_RD;
                cmd.sel    = step_reg[1:0];
                state_next = S_AWAIT;
            end
            S_AWAIT:
            begin
                cmd.sel    = step_reg[1:0];
                state_next = S_AWR;
            end
            S_AWR:
            begin
                cmd.op    = OP_ACC_WR;
                cmd.sel   = step_reg[1:0];
                step_next = step_reg + 3'd1;
                state_next = (step_reg == 3'd2) ? S_IDLE : S_ARD;
            end
            S_CLR:
            begin
                cmd.op = OP_CLR;
                if (status.clr_done)
                begin
                    cmd.op     = OP_NONE;
                    state_next = S_IDLE;
                end
            end
            S_RRD:   state_next = S_RWAIT;
            S_RWAIT:
            begin
                cmd.op     = OP_NORM;
                state_next = S_NORM;
            end
            S_NORM:  if (status.norm_done) state_next = S_OUT;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Reset starts with a clearing pass so the accumulators begin at zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            step_reg  <= '0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            bad_reg   <= bad_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_bad   = bad_reg;
endmodule
